>>> sv/pfdm_pkg.sv
// shared types, constants and tables for the pcm frame downmix block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pfdm_pkg;

    localparam int MAX_CHANNELS = 8;

    localparam int WORD_W   = 32;
    localparam int FMT_W    = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 4;
    localparam int ADDR_W   = 1;
    localparam int LANE_W   = 28;
    localparam int SUM_W    = 31;
    localparam int MAG_W    = 31;
    localparam int RECIP_W  = 33;
    localparam int AVG_W    = 29;
    localparam int CLAMP_W  = 26;
    localparam int PROD_W   = 41;
    localparam int SAMPLE_W = 16;
    localparam int FRAC_BITS = 24;

    localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_INT16   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_INT24   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_INT32   = 3'd3;

    localparam logic [ADDR_W-1:0] REG_SAMPLE_FORMAT = 1'b0;
    localparam logic [ADDR_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    localparam logic [FMT_W-1:0] FORMAT_RESET = FMT_FLOAT32;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 4'd2;

    // float exponent limits for the q4.24 conversion
    localparam logic [7:0] EXP_NAN  = 8'hFF;
    localparam logic [7:0] EXP_SAT  = 8'd130;
    localparam logic [7:0] EXP_ZERO = 8'd102;
    localparam logic [7:0] EXP_TOP  = 8'd129;

    localparam logic signed [LANE_W-1:0] Q_POS_LIMIT = 28'sh7FF_FFFF;
    localparam logic signed [LANE_W-1:0] Q_NEG_LIMIT = 28'sh800_0000;
    localparam logic signed [AVG_W-1:0]  Q_ONE       = 29'sh100_0000;
    localparam logic signed [16:0]       SCALE       = 17'sd32767;

    typedef struct packed {
        logic             is_float;
        logic             force_zero;
        logic             last;
        logic [CNT_W-1:0] cnt;
    } pfdm_ctl_t;

    // floor(2^32 / n) for n of 1 to 8
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'h0_8000_0000;
            4'd3:    r = 33'h0_5555_5555;
            4'd4:    r = 33'h0_4000_0000;
            4'd5:    r = 33'h0_3333_3333;
            4'd6:    r = 33'h0_2AAA_AAAA;
            4'd7:    r = 33'h0_2492_4924;
            4'd8:    r = 33'h0_2000_0000;
            default: r = 33'h1_0000_0000;
        endcase
        return r;
    endfunction

endpackage

>>> sv/pcm_frame_downmix_to_mono16_unit.sv
// top level of the pcm frame downmix: config registers, lanes, merge, output skid
// depends on pfdm_pkg, pfdm_lane, pfdm_merge
`timescale 1ns / 1ps

// Takes one frame of up to eight channel words per beat and returns one signed
// 16-bit mono sample per beat, with tlast carried through. Eight conversion
// lanes work on the channels of a frame side by side and a merging pipeline
// sums them, divides by the channel count (reciprocal multiply plus one
// correction step) and scales float results. A new frame is taken every clock
// cycle while the output side keeps up; each result passes from the lane
// registers, which load at the edge that takes its frame, through the sum,
// two divider stages and the scaling stage to the output register. When
// the output stalls, a skid register catches the next result and s_axis_tready
// drops in the following cycle until it drains. Registers: index 0 selects the
// sample format (0 float32, 1 int16, 2 int24, 3 int32, others give zero),
// index 1 the channel count (0 acts as 1, above 8 as 8); write them only
// while no frame is in flight.
module pcm_frame_downmix_to_mono16_unit
    import pfdm_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ADDR_W-1:0]                cfg_addr,
    input  logic [CFG_W-1:0]                 cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [MAX_CHANNELS*WORD_W-1:0]   s_axis_tdata,  // chan0_word .. chan7_word
    input  logic                             s_axis_tuser,  // silent_frame
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [SAMPLE_W-1:0]              m_axis_tdata,  // mono_sample
    output logic                             m_axis_tlast
);

    logic [FMT_W-1:0]          fmt_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          n_eff;

    logic                      en;
    logic [4:0]                vld_reg;
    pfdm_ctl_t                 ctl1_next;
    pfdm_ctl_t                 ctl1_reg;
    pfdm_ctl_t                 ctl_fin;

    logic signed [LANE_W-1:0]  lane_val [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] fin_sample;
    logic                      fin_load;

    logic                      out_vld_reg;
    logic [SAMPLE_W-1:0]       out_data_reg;
    logic                      out_last_reg;
    logic                      skid_vld_reg;
    logic [SAMPLE_W-1:0]       skid_data_reg;
    logic                      skid_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FORMAT_RESET;
            cnt_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SAMPLE_FORMAT: fmt_reg <= cfg_wdata[FMT_W-1:0];
                REG_CHANNEL_COUNT: cnt_reg <= cfg_wdata[CNT_W-1:0];
                default:           fmt_reg <= fmt_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cnt_reg == '0)
            n_eff = CNT_W'(1);
        else if (cnt_reg > CNT_W'(MAX_CHANNELS))
            n_eff = CNT_W'(MAX_CHANNELS);
        else
            n_eff = cnt_reg;
        ctl1_next.is_float   = (fmt_reg == FMT_FLOAT32);
        ctl1_next.force_zero = s_axis_tuser || (fmt_reg > FMT_INT32);
        ctl1_next.last       = s_axis_tlast;
        ctl1_next.cnt        = n_eff;
    end

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    generate
        for (genvar g = 0; g < MAX_CHANNELS; g++)
        begin : g_lane
            pfdm_lane u_lane (
                .clk      (clk),
                .en       (en),
                .word     (s_axis_tdata[g*WORD_W +: WORD_W]),
                .fmt      (fmt_reg),
                .active   (CNT_W'(g) < n_eff),
                .lane_val (lane_val[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            ctl1_reg <= ctl1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], s_axis_tvalid};
    end

    pfdm_merge u_merge (
        .clk      (clk),
        .en       (en),
        .lane_val (lane_val),
        .ctl_in   (ctl1_reg),
        .sample   (fin_sample),
        .ctl_out  (ctl_fin)
    );

    assign fin_load = en && vld_reg[4];

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg <= fin_load;
        end
        else if (fin_load)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_data_reg <= fin_sample;
                out_last_reg <= ctl_fin.last;
            end
        end
        else if (fin_load)
        begin
            skid_data_reg <= fin_sample;
            skid_last_reg <= ctl_fin.last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> sv/pfdm_lane.sv
// one channel lane: turns a raw sample word into a scaled value, registered
// depends on pfdm_pkg
`timescale 1ns / 1ps

module pfdm_lane
    import pfdm_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [WORD_W-1:0]        word,
    input  logic [FMT_W-1:0]         fmt,
    input  logic                     active,
    output logic signed [LANE_W-1:0] lane_val
);

    logic                     sgn;
    logic [7:0]               expo;
    logic [22:0]              frac;
    logic [7:0]               shamt_full;
    logic [4:0]               shamt;
    logic [26:0]              mant;
    logic [26:0]              mag;
    logic signed [LANE_W-1:0] flt_val;
    logic signed [LANE_W-1:0] val_next;
    logic signed [LANE_W-1:0] val_reg;

    always_comb
    begin
        sgn        = word[31];
        expo       = word[30:23];
        frac       = word[22:0];
        shamt_full = EXP_TOP - expo;
        shamt      = shamt_full[4:0];
        mant       = {1'b1, frac, 3'b000};
        mag        = mant >> shamt;
        if (expo == EXP_NAN && frac != '0)
            flt_val = '0;
        else if (expo >= EXP_SAT)
            flt_val = sgn ? Q_NEG_LIMIT : Q_POS_LIMIT;
        else if (expo <= EXP_ZERO)
            flt_val = '0;
        else if (sgn)
            flt_val = -$signed({1'b0, mag});
        else
            flt_val = $signed({1'b0, mag});
    end

    always_comb
    begin
        case (fmt)
            FMT_FLOAT32: val_next = flt_val;
            FMT_INT16:   val_next = {{12{word[15]}}, word[15:0]};
            FMT_INT24:   val_next = {{12{word[23]}}, word[23:8]};
            FMT_INT32:   val_next = {{12{word[31]}}, word[31:16]};
            default:     val_next = '0;
        endcase
        if (!active)
            val_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            val_reg <= val_next;
    end

    assign lane_val = val_reg;

endmodule

>>> sv/pfdm_div.sv
// two-stage divider of the channel sum by the channel count, toward zero
// depends on pfdm_pkg; reciprocal multiply then one correction step
`timescale 1ns / 1ps

module pfdm_div
    import pfdm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic signed [AVG_W-1:0] quotient
);

    logic                          neg_next;
    logic [MAG_W-1:0]              mag_next;
    logic [MAG_W+RECIP_W-1:0]      prod;
    logic [MAG_W-1:0]              q0_next;

    logic                          neg_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [MAG_W-1:0]              q0_reg;
    logic [CNT_W-1:0]              dvs_reg;

    logic [MAG_W+CNT_W-1:0]        back;
    logic [MAG_W+CNT_W-1:0]        rem;
    logic [MAG_W-1:0]              q;
    logic signed [MAG_W:0]         q_signed;
    logic signed [AVG_W-1:0]       quot_next;
    logic signed [AVG_W-1:0]       quot_reg;

    // estimate, at most one short of the true quotient
    always_comb
    begin
        neg_next = dividend[SUM_W-1];
        mag_next = neg_next ? MAG_W'(-dividend) : MAG_W'(dividend);
        prod     = {{RECIP_W{1'b0}}, mag_next} * {{MAG_W{1'b0}}, recip(divisor)};
        q0_next  = prod[MAG_W+31:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            q0_reg  <= q0_next;
            dvs_reg <= divisor;
        end
    end

    // remainder check and sign
    always_comb
    begin
        back = {{CNT_W{1'b0}}, q0_reg} * {{MAG_W{1'b0}}, dvs_reg};
        rem  = {{CNT_W{1'b0}}, mag_reg} - back;
        q    = q0_reg + MAG_W'(rem >= {{MAG_W{1'b0}}, dvs_reg});
        q_signed  = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        quot_next = q_signed[AVG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule

>>> sv/pfdm_merge.sv
// merging stage: sums the lanes, divides by the count, scales float results
// depends on pfdm_pkg and pfdm_div
`timescale 1ns / 1ps

module pfdm_merge
    import pfdm_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [LANE_W-1:0]   lane_val [MAX_CHANNELS],
    input  pfdm_ctl_t                  ctl_in,
    output logic signed [SAMPLE_W-1:0] sample,
    output pfdm_ctl_t                  ctl_out
);

    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    sum_reg;
    pfdm_ctl_t                  ctl2_reg;
    pfdm_ctl_t                  ctl3_reg;
    pfdm_ctl_t                  ctl4_reg;
    pfdm_ctl_t                  ctl5_reg;

    logic signed [AVG_W-1:0]    avg;
    logic signed [CLAMP_W-1:0]  clamp_val;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] int_reg;
    logic signed [PROD_W-1:0]   prod_adj;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
            sum_next = sum_next + SUM_W'(lane_val[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    pfdm_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (sum_reg),
        .divisor  (ctl2_reg.cnt),
        .quotient (avg)
    );

    // clamp to plus or minus one, then times 32767
    always_comb
    begin
        if (avg > Q_ONE)
            clamp_val = CLAMP_W'(Q_ONE);
        else if (avg < -Q_ONE)
            clamp_val = CLAMP_W'(-Q_ONE);
        else
            clamp_val = CLAMP_W'(avg);
        prod_next = clamp_val * SCALE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            int_reg  <= avg[SAMPLE_W-1:0];
            ctl5_reg <= ctl4_reg;
        end
    end

    // shift by 24 toward zero, then select zero, the float result or the integer average
    always_comb
    begin
        prod_adj = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(Q_ONE - AVG_W'(1)) : '0);
        if (ctl5_reg.force_zero)
            sample = '0;
        else if (ctl5_reg.is_float)
            sample = prod_adj[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        else
            sample = int_reg;
    end

    assign ctl_out = ctl5_reg;

endmodule

>>> sv/pfdm_checker.sv
// port-level checks for the pcm frame downmix top level, bound to it below
// depends on pfdm_pkg and pcm_frame_downmix_to_mono16_unit
`timescale 1ns / 1ps

module pfdm_checker
    import pfdm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // input held off only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("ready dropped without an output stall");

endmodule

bind pcm_frame_downmix_to_mono16_unit pfdm_checker u_checker (.*);

>>> tb/pcm_frame_downmix_to_mono16_unit_test.sv
// self-checking testbench for pcm_frame_downmix_to_mono16_unit: directed corners,
// a receiver hold-off that fills the pipeline, then randomized format/count phases
// depends on pfdm_pkg and the unit under test
`timescale 1ns / 1ps

module pcm_frame_downmix_to_mono16_unit_test;
    import pfdm_pkg::*;

    localparam int FRAME_W = MAX_CHANNELS * WORD_W;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 22;
    localparam int PHASE_BEATS = 50;

    localparam logic [FMT_W-1:0] FMT_UNSUPPORTED = 3'd4;
    localparam logic [FMT_W-1:0] FMT_LAST_CODE   = 3'd7;

    localparam logic [31:0] F_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] F_INF     = 32'h7F80_0000;
    localparam logic [31:0] F_NEG_INF = 32'hFF80_0000;
    localparam logic [31:0] F_NAN     = 32'h7FC0_0000;
    localparam logic [31:0] F_TOP     = 32'h40FF_FFFF;
    localparam logic [31:0] F_LSB     = 32'h3380_0000;
    localparam logic [31:0] F_TINY    = 32'h3300_0000;
    localparam logic [31:0] F_DENORM  = 32'h0000_0001;

    localparam longint Q_UNIT    = 64'sd1 << FRAC_BITS;
    localparam longint Q_SAT_POS = (64'sd1 << 27) - 1;
    localparam longint Q_SAT_NEG = -(64'sd1 << 27);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } mono_beat_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [ADDR_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [FRAME_W-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [SAMPLE_W-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;

    mono_beat_t           mono_expect_q[$];
    logic [FMT_W-1:0]     fmt_shadow;
    logic [CNT_W-1:0]     count_shadow;
    int                   mismatches;
    int                   burst_left;
    bit                   back_to_back;
    bit                   hold_req;
    int                   hold_left;
    int                   mode_left;
    int                   rx_phase;
    rx_mode_e             rx_mode;
    int                   quiet_cycles;

    pcm_frame_downmix_to_mono16_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ieee single to q4.24, truncating toward zero and saturating
    function automatic longint float_to_q424(input logic [31:0] w);
        logic [7:0]  ex;
        logic [22:0] fr;
        longint      mag;
        ex = w[30:23];
        fr = w[22:0];
        if (ex == 8'hFF && fr != '0)
            return 0;
        if (ex >= 8'd130)
            return w[31] ? Q_SAT_NEG : Q_SAT_POS;
        if (ex <= 8'd102)
            return 0;
        mag = longint'({1'b1, fr});
        if (ex >= 8'd126)
            mag = mag << (ex - 8'd126);
        else
            mag = mag >> (8'd126 - ex);
        return w[31] ? -mag : mag;
    endfunction

    function automatic logic [SAMPLE_W-1:0] downmix(input logic [FRAME_W-1:0] frame,
                                                     input logic silent,
                                                     input logic [FMT_W-1:0] fmt,
                                                     input logic [CNT_W-1:0] cnt);
        longint n;
        longint total;
        longint avg;
        int     i;
        n = (cnt == 0) ? 1 : (cnt > MAX_CHANNELS) ? MAX_CHANNELS : longint'(cnt);
        total = 0;
        if (silent)
            return '0;
        case (fmt)
            FMT_FLOAT32:
            begin
                for (i = 0; i < n; i++)
                    total += float_to_q424(frame[i*WORD_W +: WORD_W]);
                avg = total / n;
                if (avg > Q_UNIT)
                    avg = Q_UNIT;
                if (avg < -Q_UNIT)
                    avg = -Q_UNIT;
                avg = (avg * 32767) / Q_UNIT;
            end
            FMT_INT16:
            begin
                for (i = 0; i < n; i++)
                    total += longint'($signed(frame[i*WORD_W +: 16]));
                avg = total / n;
            end
            FMT_INT24:
            begin
                for (i = 0; i < n; i++)
                    total += longint'($signed(frame[i*WORD_W +: 24])) >>> 8;
                avg = total / n;
            end
            FMT_INT32:
            begin
                for (i = 0; i < n; i++)
                    total += longint'($signed(frame[i*WORD_W +: WORD_W])) >>> 16;
                avg = total / n;
            end
            default:
                return '0;
        endcase
        return avg[SAMPLE_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] two_chan(input logic [31:0] a,
                                                     input logic [31:0] b);
        return {{(MAX_CHANNELS-2){32'h0}}, b, a};
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 11))
            0:       return F_ONE;
            1:       return F_NEG_ONE;
            2:       return F_INF;
            3:       return F_NEG_INF;
            4:       return F_NAN;
            5:       return F_TOP;
            6:       return 32'h7FFF_FFFF;
            7:       return 32'h8000_0000;
            8:       return 32'hFFFF_8000;
            9:       return 32'h0000_7FFF;
            10:      return 32'hFF80_0000;
            default: return 32'h007F_FFFF;
        endcase
    endfunction

    // floats mostly in the interesting exponent band, some specials and raw noise
    function automatic logic [31:0] random_float_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0:       w[30:23] = 8'hFF;
            1:       w[30:23] = 8'h00;
            8, 9:    ;
            default: w[30:23] = 8'($urandom_range(100, 131));
        endcase
        if ($urandom_range(0, 15) == 0)
            w[22:0] = '0;
        return w;
    endfunction

    function automatic logic [FRAME_W-1:0] random_frame(input logic [FMT_W-1:0] fmt);
        logic [FRAME_W-1:0] frame;
        int                 i;
        for (i = 0; i < MAX_CHANNELS; i++)
            frame[i*WORD_W +: WORD_W] = (fmt == FMT_FLOAT32) ? random_float_word() : $urandom;
        if ($urandom_range(0, 5) == 0)
            frame = {MAX_CHANNELS{corner_word()}};
        return frame;
    endfunction

    task automatic send_frame(input logic [FRAME_W-1:0] frame, input logic silent,
                              input logic last_mark);
        mono_beat_t beat;
        int         gap;
        if (burst_left == 0 && !back_to_back)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        s_axis_tuser  <= silent;
        s_axis_tlast  <= last_mark;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beat.sample = downmix(frame, silent, fmt_shadow, count_shadow);
        beat.last = last_mark;
        mono_expect_q.push_back(beat);
    endtask

    task automatic send_random(input int beats);
        int k;
        for (k = 0; k < beats; k++)
            send_frame(random_frame(fmt_shadow), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 3) == 0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mono_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SAMPLE_FORMAT)
            fmt_shadow = val[FMT_W-1:0];
        else
            count_shadow = val;
        @(posedge clk);
    endtask

    task automatic test_directed();
        logic [FMT_W-1:0] f;
        // reset values: float32, two channels
        send_frame(two_chan(F_ONE, F_ONE), 1'b0, 1'b0);
        send_frame(two_chan(F_NEG_ONE, F_NEG_ONE), 1'b0, 1'b0);
        send_frame(two_chan(F_NAN, F_ONE), 1'b0, 1'b0);
        send_frame(two_chan(F_INF, F_NEG_INF), 1'b0, 1'b0);
        send_frame(two_chan(F_DENORM, F_TINY), 1'b0, 1'b0);
        send_frame(two_chan(F_LSB, F_TOP), 1'b0, 1'b1);
        send_frame(two_chan(F_ONE, F_ONE), 1'b1, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 4'd8);
        send_frame({MAX_CHANNELS{F_INF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{F_NEG_INF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{F_TOP}}, 1'b0, 1'b1);
        // bit 3 of the format write is dropped
        write_reg(REG_SAMPLE_FORMAT, {1'b1, FMT_INT16});
        write_reg(REG_CHANNEL_COUNT, 4'd1);
        send_frame({MAX_CHANNELS{32'hFFFF_7FFF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{32'h0000_8000}}, 1'b0, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 4'd8);
        send_frame({MAX_CHANNELS{32'h0000_8000}}, 1'b0, 1'b0);
        send_frame(two_chan(32'h0000_7FFF, 32'h0000_8000), 1'b0, 1'b1);
        write_reg(REG_SAMPLE_FORMAT, {1'b0, FMT_INT24});
        send_frame({MAX_CHANNELS{32'h007F_FFFF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{32'hFF80_0000}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{32'h00FF_FFFF}}, 1'b0, 1'b0);
        write_reg(REG_SAMPLE_FORMAT, {1'b0, FMT_INT32});
        write_reg(REG_CHANNEL_COUNT, 4'd15);
        send_frame({MAX_CHANNELS{32'h7FFF_FFFF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{32'h8000_0000}}, 1'b0, 1'b1);
        send_frame({MAX_CHANNELS{32'h8000_0000}}, 1'b1, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 4'd0);
        send_frame({MAX_CHANNELS{32'hFFFF_FFFF}}, 1'b0, 1'b0);
        send_frame({MAX_CHANNELS{32'h0001_0000}}, 1'b0, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 4'd3);
        for (f = FMT_UNSUPPORTED; f <= FMT_LAST_CODE && f >= FMT_UNSUPPORTED; f++)
        begin
            write_reg(REG_SAMPLE_FORMAT, {1'b0, f});
            send_frame({MAX_CHANNELS{32'h7FFF_FFFF}}, 1'b0, f[0]);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(REG_SAMPLE_FORMAT, {1'b0, FMT_INT16});
        write_reg(REG_CHANNEL_COUNT, 4'd4);
        hold_req = 1'b1;
        back_to_back = 1'b1;
        send_random(60);
        back_to_back = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int               p;
        logic [FMT_W-1:0] f;
        logic [CNT_W-1:0] c;
        for (p = 0; p < PHASES; p++)
        begin
            f = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                            : 3'($urandom_range(0, 3));
            c = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
            write_reg(REG_SAMPLE_FORMAT, {1'($urandom_range(0, 1)), f});
            write_reg(REG_CHANNEL_COUNT, c);
            send_random(PHASE_BEATS);
        end
    endtask

    // result side: stall patterns that change over time, plus the requested hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        rx_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 9) != 0);
                default:   m_axis_tready <= (rx_phase % 7) < 4;
            endcase
        end
    end

    always @(posedge clk)
    begin
        mono_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (mono_expect_q.size() == 0)
            begin
                $display("%0t: unexpected beat, mono_sample %0d tlast %0b", $time,
                         $signed(m_axis_tdata), m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = mono_expect_q.pop_front();
                if (m_axis_tdata !== want.sample)
                begin
                    $display("%0t: mono_sample expected %0d got %0d", $time,
                             $signed(want.sample), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: tlast expected %0b got %0b", $time, want.last,
                             m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("pcm_frame_downmix_to_mono16_unit_test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        burst_left = 0;
        back_to_back = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        mode_left = 0;
        rx_phase = 0;
        rx_mode = RX_OPEN;
        quiet_cycles = 0;
        fmt_shadow = FORMAT_RESET;
        count_shadow = COUNT_RESET;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        s_axis_tlast <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("pcm_frame_downmix_to_mono16_unit_test passed");
        else
            $display("pcm_frame_downmix_to_mono16_unit_test failed");
        $finish;
    end

endmodule

>>> files.f
sv/pfdm_pkg.sv
sv/pfdm_lane.sv
sv/pfdm_div.sv
sv/pfdm_merge.sv
sv/pcm_frame_downmix_to_mono16_unit.sv
sv/pfdm_checker.sv
tb/pcm_frame_downmix_to_mono16_unit_test.sv
